@@ rtl/rdc_pkg.sv @@
// Package for the radix digit converter: shared widths, register reset
// values, the sequencer state type and the digit stack control structs.
// No dependencies.
`timescale 1ns / 1ps

package rdc_pkg;

   // Digit and radix widths are fixed by the result format
   localparam int RADIX_W = 8;
   localparam int DIGIT_W = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_ZERO = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_DIVIDE,
      ST_READ,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the digit stack
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

   // Status from the digit stack back to the sequencer
   typedef struct packed {
      logic empty;
      logic full;
   } stk_stat_type;

endpackage

@@ rtl/rdc_if.sv @@
// Valid/ready channel interfaces for the radix digit converter: the request
// channel carries the value, the response channel one digit per transaction.
// Depends on rdc_pkg.
`timescale 1ns / 1ps

interface rdc_req_if #(
   parameter int VALUE_BITS = 31
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdc_rsp_if
   import rdc_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic               last;
   logic               status;

   modport source (output valid, output digit, output last, output status, input ready);
   modport sink   (input valid, input digit, input last, input status, output ready);
endinterface

@@ rtl/rdc_divider.sv @@
// Bit-serial restoring divider: divides a value by the radix, one quotient
// bit per cycle, most significant bit first.
// Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_divider
   import rdc_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_W-1:0]    radix,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [RADIX_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [RADIX_W-1:0]    r_ff, r_in;
   logic [RADIX_W:0]      trial;
   logic                  fits;

   // Shift the next dividend bit into the partial remainder and try a subtract
   assign trial = {r_ff, q_ff[VALUE_BITS-1]};
   assign fits  = (trial >= {1'b0, radix});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_BITS - 1);
         q_in    = dividend;
         r_in    = '0;
      end else if (busy_ff) begin
         q_in = {q_ff[VALUE_BITS-2:0], fits};
         r_in = fits ? RADIX_W'(trial - {1'b0, radix}) : trial[RADIX_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

@@ rtl/rdc_digit_stack.sv @@
// Digit stack: a small memory with a fill count; push writes at the top,
// pop reads the top entry into a registered read port.
// Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_digit_stack
   import rdc_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  stk_ctrl_type       ctrl,
   input  logic [DIGIT_W-1:0] wr_digit,
   output stk_stat_type       stat,
   output logic [DIGIT_W-1:0] rd_digit
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [DIGIT_W-1:0] mem [STACK_DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      count_dec;
   logic [DIGIT_W-1:0] rd_ff;

   assign count_dec = count_ff - 1'b1;

   // Advance the fill count on push and pop
   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Memory write at the top and registered read of the entry below it
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[count_ff[AW-1:0]] <= wr_digit;
      end
      if (ctrl.pop) begin
         rd_ff <= mem[count_dec[AW-1:0]];
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(STACK_DEPTH));
   assign rd_digit   = rd_ff;

endmodule

@@ rtl/radix_digit_converter.sv @@
// Top level of the radix digit converter: radix register, conversion
// sequencer and response output register.
// Depends on rdc_pkg, rdc_if, rdc_divider and rdc_digit_stack.
`timescale 1ns / 1ps

// Converts each request value to digits in the programmed radix and returns
// one response transaction per digit, most significant first, with last set
// on the final one. A zero value returns a single response with status set.
// Each digit is computed in the bit-serial divider, and the digits then leave
// the stack at up to one per cycle while the output register is free. One
// request is converted at a time; the next request is taken once the final
// response is in the output register. Radix writes of 0 or 1 are held at 2;
// write the radix only while idle. If a value has more than STACK_DEPTH
// digits, only the STACK_DEPTH least significant digits are returned.
module radix_digit_converter
   import rdc_pkg::*;
#(
   parameter int VALUE_BITS  = 31,
   parameter int STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   rdc_req_if.sink            req_chan,
   rdc_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [RADIX_W-1:0] csr_wr_data
);

   state_type             state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;

   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [RADIX_W-1:0]    div_remainder;

   stk_ctrl_type          stk_ctrl;
   stk_stat_type          stk_stat;
   logic [DIGIT_W-1:0]    stk_rd_digit;

   logic                  out_free;
   logic                  out_load;
   logic [DIGIT_W-1:0]    out_digit;
   logic                  out_last;
   logic                  out_status;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]    digit_ff;
   logic                  last_ff;
   logic                  status_ff;

   // Radix register, clamp small bases to two
   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en) begin
         radix_in = (csr_wr_data < RADIX_MIN) ? RADIX_MIN : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   rdc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   rdc_digit_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stk_ctrl),
      .wr_digit (div_remainder),
      .stat     (stk_stat),
      .rd_digit (stk_rd_digit)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer: divide until the quotient is zero, then pop the digits out; a zero value gets a single zero response
   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      div_dividend   = req_chan.value;
      stk_ctrl       = '0;
      out_load       = 1'b0;
      out_digit      = stk_rd_digit;
      out_last       = 1'b0;
      out_status     = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (req_chan.value == '0) begin
                  state_in = ST_ZERO;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_digit  = '0;
               out_last   = 1'b1;
               out_status = STATUS_ZERO;
               state_in   = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // drop digits beyond the stack depth
               stk_ctrl.push = !stk_stat.full;
               if (div_quotient == '0) begin
                  state_in = ST_READ;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end
            end
         end
         ST_READ: begin
            stk_ctrl.pop = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = stk_stat.empty;
               if (stk_stat.empty) begin
                  state_in = ST_IDLE;
               end else begin
                  stk_ctrl.pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output register: hold the transaction until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         digit_ff  <= out_digit;
         last_ff   <= out_last;
         status_ff <= out_status;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.digit  = digit_ff;
   assign rsp_chan.last   = last_ff;
   assign rsp_chan.status = status_ff;

endmodule
